// File: rtl/tca_pkg.sv
// Shared types and constants for the top-k classifier accuracy block.
package tca_pkg;

    localparam int SCORE_BITS = 8;
    localparam int CLASS_BITS = 10;
    localparam int COUNT_BITS = 20;
    localparam int TOP_K      = 5;
    localparam int FILL_BITS  = $clog2(TOP_K + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Ranking state: entry 0 holds the highest score.
    typedef struct packed {
        logic [TOP_K-1:0][SCORE_BITS-1:0] scores;
        logic [TOP_K-1:0][CLASS_BITS-1:0] classes;
        logic [FILL_BITS-1:0]             filled;
    } rank_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]            images_total;
        logic [COUNT_BITS-1:0]            top5_total;
        logic [COUNT_BITS-1:0]            top1_total;
        logic                             top5_hit;
        logic                             top1_hit;
        logic [TOP_K-1:0][CLASS_BITS-1:0] classes;
        logic [SCORE_BITS-1:0]            top_score;
    } result_t;

endpackage

// File: rtl/topk_classifier_accuracy.sv
// Top level of the top-5 classification accuracy block.
//
// The slave stream carries one class score per transaction; the class index is
// the arrival order within the image, and tlast marks the final score of an
// image, whose transaction also carries the true class. After each image the
// master stream delivers one transaction with the five ranked classes, the top
// score, top-1 and top-5 hit flags and saturating running totals.
// A score is registered at acceptance and ranked from that register by five
// parallel compares, so one score per cycle is taken when the receiver keeps up.
// A result is written to the output register when its last score leaves the
// input register, and waits there until taken. While a result waits,
// non-last scores keep flowing; only a second last score stalls the input.
// Among equal scores the lower class index ranks first.
// Reset clears the ranking, the class counter, the totals and both valid flags;
// no clearing pass is needed, the block accepts data as soon as reset is released.
module topk_classifier_accuracy
    import tca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,  // score[7:0], true_class[17:8], zero[23:18]
    input  logic         s_tlast,  // last score of the image
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata   // top_class[9:0], top_score[17:10],
                                   // second_class[27:18], third_class[37:28],
                                   // fourth_class[47:38], fifth_class[57:48],
                                   // top1_hit[58], top5_hit[59],
                                   // top1_total[79:60], top5_total[99:80],
                                   // images_total[119:100]
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [SCORE_BITS-1:0] s1_score_reg;
    logic                  s1_last_reg;
    logic [CLASS_BITS-1:0] s1_truth_reg;
    rank_t                 rank_reg, rank_next;
    logic [CLASS_BITS-1:0] class_cnt_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;

    logic    s_fire;
    logic    out_free;
    logic    s1_fire;
    logic    img_done;
    rank_t   rank_ins;
    result_t res;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign img_done = s1_fire && s1_last_reg;
    assign s_tready = !s1_valid_reg || s1_fire;

    tca_insert u_insert (
        .cur       (rank_reg),
        .score     (s1_score_reg),
        .class_idx (class_cnt_reg),
        .nxt       (rank_ins)
    );

    tca_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (img_done),
        .rank  (rank_ins),
        .truth (s1_truth_reg),
        .res   (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // The ranking clears once the last score of an image has been reported.
    always_comb
    begin
        rank_next = rank_reg;
        if (img_done)
        begin
            rank_next = '0;
        end
        else if (s1_fire)
        begin
            rank_next = rank_ins;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (img_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rank_reg      <= '0;
            class_cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rank_reg      <= rank_next;
            if (img_done)
            begin
                class_cnt_reg <= '0;
            end
            else if (s1_fire)
            begin
                class_cnt_reg <= class_cnt_reg + CLASS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_score_reg <= s_tdata[SCORE_BITS-1:0];
            s1_last_reg  <= s_tlast;
            s1_truth_reg <= s_tdata[SCORE_BITS +: CLASS_BITS];
        end
        if (img_done)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.images_total, out_reg.top5_total, out_reg.top1_total,
                       out_reg.top5_hit, out_reg.top1_hit,
                       out_reg.classes[4], out_reg.classes[3], out_reg.classes[2],
                       out_reg.classes[1], out_reg.top_score, out_reg.classes[0]};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg.filled <= FILL_BITS'(TOP_K))
        else $error("ranking fill count exceeds the number of ranks");

    a_clear_after_image: assert property (@(posedge clk) disable iff (!rst_n)
        img_done |=> (rank_reg.filled == '0) && (class_cnt_reg == '0))
        else $error("ranking not cleared after the last score of an image");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.top1_hit |-> out_reg.top5_hit)
        else $error("top-1 hit reported without a top-5 hit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        img_done |-> !out_valid_reg || m_tready)
        else $error("result register overwritten before it was taken");

endmodule

// File: rtl/tca_insert.sv
// Combinational insertion of one score into the sorted top-k ranking.
module tca_insert
    import tca_pkg::*;
(
    input  rank_t                 cur,
    input  logic [SCORE_BITS-1:0] score,
    input  logic [CLASS_BITS-1:0] class_idx,
    output rank_t                 nxt
);

    logic [TOP_K-1:0]                 gt;
    logic [TOP_K-1:0]                 prev_gt;
    logic [TOP_K-1:0][SCORE_BITS-1:0] shift_scores;
    logic [TOP_K-1:0][CLASS_BITS-1:0] shift_classes;

    // An empty rank always loses to the new score. Filled ranks are sorted, so
    // gt is a thermometer code: the first set bit is the insertion point.
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            gt[i] = (FILL_BITS'(i) >= cur.filled) || (score > cur.scores[i]);
        end
    end

    assign prev_gt       = {gt[TOP_K-2:0], 1'b0};
    assign shift_scores  = {cur.scores[TOP_K-2:0], {SCORE_BITS{1'b0}}};
    assign shift_classes = {cur.classes[TOP_K-2:0], {CLASS_BITS{1'b0}}};

    always_comb
    begin
        nxt = cur;
        for (int i = 0; i < TOP_K; i++)
        begin
            if (gt[i] && !prev_gt[i])
            begin
                nxt.scores[i]  = score;
                nxt.classes[i] = class_idx;
            end
            else if (gt[i])
            begin
                nxt.scores[i]  = shift_scores[i];
                nxt.classes[i] = shift_classes[i];
            end
        end
        if (cur.filled < FILL_BITS'(TOP_K))
        begin
            nxt.filled = cur.filled + FILL_BITS'(1);
        end
    end

endmodule

// File: rtl/tca_tally.sv
// Hit detection and saturating running totals for each finished image.
module tca_tally
    import tca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  rank_t                 rank,
    input  logic [CLASS_BITS-1:0] truth,
    output result_t               res
);

    logic [COUNT_BITS-1:0] top1_cnt_reg, top1_cnt_next;
    logic [COUNT_BITS-1:0] top5_cnt_reg, top5_cnt_next;
    logic [COUNT_BITS-1:0] img_cnt_reg, img_cnt_next;
    logic [TOP_K-1:0][CLASS_BITS-1:0] cls;
    logic                  hit1;
    logic                  hit5;

    always_comb
    begin
        hit5 = 1'b0;
        for (int i = 0; i < TOP_K; i++)
        begin
            if (FILL_BITS'(i) < rank.filled)
            begin
                cls[i] = rank.classes[i];
            end
            else
            begin
                cls[i] = '0;
            end
            if ((FILL_BITS'(i) < rank.filled) && (rank.classes[i] == truth))
            begin
                hit5 = 1'b1;
            end
        end
        hit1 = (rank.filled != '0) && (rank.classes[0] == truth);
    end

    always_comb
    begin
        top1_cnt_next = top1_cnt_reg;
        top5_cnt_next = top5_cnt_reg;
        img_cnt_next  = img_cnt_reg;
        if (hit1 && (top1_cnt_reg != COUNT_MAX))
        begin
            top1_cnt_next = top1_cnt_reg + COUNT_BITS'(1);
        end
        if (hit5 && (top5_cnt_reg != COUNT_MAX))
        begin
            top5_cnt_next = top5_cnt_reg + COUNT_BITS'(1);
        end
        if (img_cnt_reg != COUNT_MAX)
        begin
            img_cnt_next = img_cnt_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top1_cnt_reg <= '0;
            top5_cnt_reg <= '0;
            img_cnt_reg  <= '0;
        end
        else if (upd)
        begin
            top1_cnt_reg <= top1_cnt_next;
            top5_cnt_reg <= top5_cnt_next;
            img_cnt_reg  <= img_cnt_next;
        end
    end

    always_comb
    begin
        res.classes      = cls;
        res.top_score    = (rank.filled != '0) ? rank.scores[0] : '0;
        res.top1_hit     = hit1;
        res.top5_hit     = hit5;
        res.top1_total   = top1_cnt_next;
        res.top5_total   = top5_cnt_next;
        res.images_total = img_cnt_next;
    end

endmodule
